// ===== hw/rtl/sldf_pkg.sv =====
// Types and constants shared by the sync/length frame deframer.
// No dependencies; compile first.
package sldf_pkg;

    localparam logic [7:0]  SYNC_BYTE_RESET   = 8'd0;
    localparam logic [15:0] STALE_LIMIT_RESET = 16'd1000;
    localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

    // Header byte slots while collecting: sync seen, low length held.
    localparam logic [1:0]  HDR_HUNT    = 2'd0;
    localparam logic [1:0]  HDR_GOT_SYNC = 2'd1;
    localparam logic [1:0]  HDR_GOT_LOW = 2'd2;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_BYTE = 2'd0,
        CFG_STALE_LIMIT = 2'd1,
        CFG_MAX_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_WRITE_START = 1'b0,
        OP_BYTE        = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_BYTE   = 3'd1,
        EV_LAST   = 3'd2,
        EV_STALE  = 3'd3,
        EV_JUNK   = 3'd4,
        EV_BADLEN = 3'd5
    } event_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic [7:0]  link_tag;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_offset;
        logic [15:0] frame_length;
        logic [31:0] resync_total;
        logic [31:0] frame_total;
        logic [7:0]  link_tag_out;
    } result_t;

endpackage

// ===== hw/rtl/sldf_ifs.sv =====
// Valid/ready channel interfaces for the deframer: input items, results,
// configuration writes. Depends on sldf_pkg for the config widths.
interface sldf_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
    logic [7:0]  link_tag;

    modport source (output valid, output op, output data_byte, output now_ms,
                    output link_tag, input ready);
    modport sink (input valid, input op, input data_byte, input now_ms,
                  input link_tag, output ready);
endinterface

interface sldf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic [15:0] frame_length;
    logic [31:0] resync_total;
    logic [31:0] frame_total;
    logic [7:0]  link_tag_out;

    modport source (output valid, output event_res, output payload_byte,
                    output byte_offset, output frame_length, output resync_total,
                    output frame_total, output link_tag_out, input ready);
    modport sink (input valid, input event_res, input payload_byte,
                  input byte_offset, input frame_length, input resync_total,
                  input frame_total, input link_tag_out, output ready);
endinterface

interface sldf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sldf_pkg::CFG_IDX_W-1:0]   index;
    logic [sldf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sldf_core.sv =====
// Deframer state, configuration registers and the per-beat step logic.
// Depends on sldf_pkg and sldf_cfg_if.
module sldf_core (
    input  logic              clk,
    input  logic              rst_n,
    sldf_cfg_if.sink          cfg,
    input  logic              accept,
    input  sldf_pkg::item_t   item,
    output sldf_pkg::result_t result
);

    logic [7:0]  sync_byte_reg;
    logic [15:0] stale_limit_reg;
    logic [15:0] max_len_reg;

    logic [1:0]  header_count_reg, header_count_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] expected_len_reg, expected_len_next;
    logic [15:0] received_len_reg, received_len_next;
    logic [31:0] frame_start_reg, frame_start_next;
    logic [31:0] write_time_reg, write_time_next;
    logic [31:0] resync_reg, resync_next;
    logic [31:0] frame_cnt_reg, frame_cnt_next;

    logic [31:0] age;
    logic        stale;
    logic [15:0] hdr_len;
    logic [15:0] rx_inc;
    logic        bump_resync;
    logic        bump_frame;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= sldf_pkg::SYNC_BYTE_RESET;
            stale_limit_reg <= sldf_pkg::STALE_LIMIT_RESET;
            max_len_reg     <= sldf_pkg::MAX_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sldf_pkg::CFG_SYNC_BYTE:   sync_byte_reg   <= cfg.data[7:0];
                sldf_pkg::CFG_STALE_LIMIT: stale_limit_reg <= cfg.data;
                sldf_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    assign age     = item.now_ms - frame_start_reg;
    // Negative age is never stale.
    assign stale   = !age[31] && (age > {16'd0, stale_limit_reg});
    assign hdr_len = {item.data_byte, length_low_reg};
    assign rx_inc  = received_len_reg + 16'd1;

    always_comb
    begin
        header_count_next = header_count_reg;
        length_low_next   = length_low_reg;
        expected_len_next = expected_len_reg;
        received_len_next = received_len_reg;
        frame_start_next  = frame_start_reg;
        write_time_next   = write_time_reg;
        bump_resync       = 1'b0;
        bump_frame        = 1'b0;

        result.event_res    = sldf_pkg::EV_NONE;
        result.payload_byte = 8'd0;
        result.byte_offset  = 16'd0;
        result.frame_length = 16'd0;
        result.link_tag_out = item.link_tag;

        priority if (item.op == sldf_pkg::OP_WRITE_START)
        begin
            write_time_next = item.now_ms;
            if ((header_count_reg != sldf_pkg::HDR_HUNT || expected_len_reg != 16'd0)
                && stale)
            begin
                header_count_next = sldf_pkg::HDR_HUNT;
                expected_len_next = 16'd0;
                received_len_next = 16'd0;
                bump_resync       = 1'b1;
                result.event_res  = sldf_pkg::EV_STALE;
            end
        end
        else if (expected_len_reg == 16'd0)
        begin
            frame_start_next = write_time_reg;
            priority case (header_count_reg)
                sldf_pkg::HDR_HUNT:
                begin
                    if (item.data_byte != sync_byte_reg)
                    begin
                        bump_resync      = 1'b1;
                        result.event_res = sldf_pkg::EV_JUNK;
                    end
                    else
                    begin
                        header_count_next = sldf_pkg::HDR_GOT_SYNC;
                    end
                end
                sldf_pkg::HDR_GOT_SYNC:
                begin
                    length_low_next   = item.data_byte;
                    header_count_next = sldf_pkg::HDR_GOT_LOW;
                end
                default:
                begin
                    header_count_next = sldf_pkg::HDR_HUNT;
                    received_len_next = 16'd0;
                    if (hdr_len == 16'd0 || hdr_len > max_len_reg)
                    begin
                        expected_len_next   = 16'd0;
                        bump_resync         = 1'b1;
                        result.event_res    = sldf_pkg::EV_BADLEN;
                        result.frame_length = hdr_len;
                    end
                    else
                    begin
                        expected_len_next = hdr_len;
                    end
                end
            endcase
        end
        else
        begin
            result.payload_byte = item.data_byte;
            result.byte_offset  = received_len_reg;
            result.frame_length = expected_len_reg;
            if (rx_inc >= expected_len_reg)
            begin
                bump_frame        = 1'b1;
                expected_len_next = 16'd0;
                received_len_next = 16'd0;
                result.event_res  = sldf_pkg::EV_LAST;
            end
            else
            begin
                received_len_next = rx_inc;
                result.event_res  = sldf_pkg::EV_BYTE;
            end
        end

        resync_next = resync_reg + {31'd0, bump_resync};
        frame_cnt_next = frame_cnt_reg + {31'd0, bump_frame};
        result.resync_total = resync_next;
        result.frame_total  = frame_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= sldf_pkg::HDR_HUNT;
            length_low_reg   <= 8'd0;
            expected_len_reg <= 16'd0;
            received_len_reg <= 16'd0;
            frame_start_reg  <= 32'd0;
            write_time_reg   <= 32'd0;
            resync_reg       <= 32'd0;
            frame_cnt_reg    <= 32'd0;
        end
        else if (accept)
        begin
            header_count_reg <= header_count_next;
            length_low_reg   <= length_low_next;
            expected_len_reg <= expected_len_next;
            received_len_reg <= received_len_next;
            frame_start_reg  <= frame_start_next;
            write_time_reg   <= write_time_next;
            resync_reg       <= resync_next;
            frame_cnt_reg    <= frame_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_hdr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg != 2'd3)
        else $error("header count reached an unused code");

    a_no_hdr_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        expected_len_reg != 16'd0 |-> header_count_reg == sldf_pkg::HDR_HUNT)
        else $error("header collection during payload");

    a_offset_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        expected_len_reg != 16'd0 |-> received_len_reg < expected_len_reg)
        else $error("payload offset ran past frame length");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(resync_reg) && $stable(frame_cnt_reg)
                    && $stable(expected_len_reg))
        else $error("deframer state moved without an accepted beat");

    a_frame_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.event_res == sldf_pkg::EV_LAST
        |=> frame_cnt_reg == $past(frame_cnt_reg) + 32'd1)
        else $error("last payload byte did not count a frame");
`endif

endmodule

// ===== hw/rtl/sldf_out_reg.sv =====
// Result register of the deframer: holds one result beat until the sink
// takes it. Depends on sldf_pkg and sldf_out_if.
module sldf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sldf_pkg::result_t result,
    output logic              can_load,
    sldf_out_if.source        tx
);

    logic              valid_reg;
    logic              valid_next;
    sldf_pkg::result_t data_reg;

    // Refill in the same cycle the held beat drains.
    assign can_load   = !valid_reg || tx.ready;
    assign valid_next = load || (valid_reg && !tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.event_res    = data_reg.event_res;
    assign tx.payload_byte = data_reg.payload_byte;
    assign tx.byte_offset  = data_reg.byte_offset;
    assign tx.frame_length = data_reg.frame_length;
    assign tx.resync_total = data_reg.resync_total;
    assign tx.frame_total  = data_reg.frame_total;
    assign tx.link_tag_out = data_reg.link_tag_out;

endmodule

// ===== hw/rtl/sync_length_frame_deframer.sv =====
// Top level of the sync/length-prefix byte-stream deframer.
// Depends on sldf_pkg, sldf_ifs, sldf_core and sldf_out_reg.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  rx      | in  | op, data_byte, now_ms, link_tag
//  tx      | out | event_res, payload_byte, byte_offset, frame_length,
//          |     | resync_total, frame_total, link_tag_out
//  cfg     | in  | index (0 sync byte, 1 stale limit, 2 max length), data
//
//  One rx beat per cycle unless tx stalls; each beat yields one tx beat from the
//  result register, computed in a single pass against the frame state.
//  rx is ready while the result register is empty or draining in that cycle,
//  so a stalled tx holds rx after one beat. cfg is always ready.
//  Reset clears frame state, counters and the result valid; config registers
//  return to sync 0, stale limit 1000 ms, max length 1024.
module sync_length_frame_deframer (
    input  logic     clk,
    input  logic     rst_n,
    sldf_in_if.sink  rx,
    sldf_out_if.source tx,
    sldf_cfg_if.sink cfg
);

    sldf_pkg::item_t   item;
    sldf_pkg::result_t result;
    logic              accept;
    logic              can_load;

    assign rx.ready = can_load;
    assign accept   = rx.valid && can_load;

    assign item.op        = rx.op;
    assign item.data_byte = rx.data_byte;
    assign item.now_ms    = rx.now_ms;
    assign item.link_tag  = rx.link_tag;

    sldf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .result (result)
    );

    sldf_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .tx       (tx)
    );

endmodule
